[hw/rtl/swerve_drive_wheel_kinematics_top_macros.svh]
// assertion macros for the swerve kinematics checker
`ifndef SWERVE_DRIVE_WHEEL_KINEMATICS_TOP_MACROS_SVH
`define SWERVE_DRIVE_WHEEL_KINEMATICS_TOP_MACROS_SVH
// implication checked every clock outside reset
`define SWK_ASSERT_IMP(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed");
// next-cycle implication checked outside reset
`define SWK_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed");
`endif

[hw/rtl/swk_pkg.sv]
// package: types, constants and the atan table for the swerve kinematics block
`timescale 1ns / 1ps
package swk_pkg;
   localparam int CORDIC_STAGES = 16;
   localparam int XW = 40;
   localparam int ZW = 28;
   localparam int QDEPTH = 4;
   localparam int QAW = 2;
   localparam logic signed [17:0] COS45_Q16 = 18'sd46341;
   localparam logic signed [ZW-1:0] HALF_PI_Q24 = 28'sd26353589;
   localparam logic [23:0] GAIN_Q24 = 24'd10188014;
   localparam logic [17:0] SPEED_MAX = 18'd262143;
   localparam logic signed [15:0] ANGLE_MAX = 16'sd25736;

   localparam logic [0:0] CSR_DRIVE_MODE = 1'b0;
   localparam logic [0:0] CSR_ROT_RADIUS = 1'b1;

   typedef struct packed {
      logic signed [15:0] vel_x;
      logic signed [15:0] vel_y;
      logic signed [15:0] yaw_rate;
   } req_type;

   typedef struct packed {
      logic [17:0] speed_front_left;
      logic [17:0] speed_front_right;
      logic [17:0] speed_back_left;
      logic [17:0] speed_back_right;
      logic signed [15:0] angle_front_left;
      logic signed [15:0] angle_front_right;
      logic signed [15:0] angle_back_left;
      logic signed [15:0] angle_back_right;
      logic motors_enabled;
   } rsp_type;

   // one wheel vector handed from front to back
   typedef struct packed {
      logic signed [23:0] x;
      logic signed [23:0] y;
   } wvec_type;

   typedef struct packed {
      logic enabled;
      wvec_type [3:0] wheel;
   } job_type;

   typedef struct packed {
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
      logic signed [ZW-1:0] z;
      logic zero;
   } cstage_type;

   function automatic logic signed [ZW-1:0] atan_q24(input int i);
      logic signed [ZW-1:0] t;
      case (i)
         0: t = 28'sd13176795;
         1: t = 28'sd7778716;
         2: t = 28'sd4110060;
         3: t = 28'sd2086331;
         4: t = 28'sd1047214;
         5: t = 28'sd524117;
         6: t = 28'sd262123;
         7: t = 28'sd131069;
         default: t = (i < 24) ? (28'sd65536 >>> (i - 8)) : 28'sd0;
      endcase
      return t;
   endfunction
endpackage

[hw/rtl/swk_front.sv]
// front end: rotation term and wheel vectors, two registered stages
`timescale 1ns / 1ps
module swk_front import swk_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  req_type in_item,
   input  logic    drive_mode,
   input  logic [11:0] rot_radius,
   input  logic    advance,
   output logic    out_valid,
   output job_type out_job
);
   logic v1_ff, v2_ff;
   logic en1_ff;
   logic signed [15:0] vx1_ff, vy1_ff;
   logic signed [28:0] rv1_ff;
   logic signed [46:0] prod;
   logic signed [26:0] d;
   logic signed [23:0] dn;
   job_type job_in, job_ff;

   assign prod = rv1_ff * COS45_Q16 + 47'sd524288;
   assign d = prod[46:20];
   assign dn = d[23:0];

   always_comb begin
      job_in.enabled = en1_ff;
      job_in.wheel[0].x = 24'(vx1_ff) - dn;
      job_in.wheel[0].y = 24'(vy1_ff) - dn;
      job_in.wheel[1].x = 24'(vx1_ff) - dn;
      job_in.wheel[1].y = 24'(vy1_ff) + dn;
      job_in.wheel[2].x = 24'(vx1_ff) + dn;
      job_in.wheel[2].y = 24'(vy1_ff) - dn;
      job_in.wheel[3].x = 24'(vx1_ff) + dn;
      job_in.wheel[3].y = 24'(vy1_ff) + dn;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
      if (advance) begin
         en1_ff <= drive_mode;
         vx1_ff <= in_item.vel_x;
         vy1_ff <= in_item.vel_y;
         rv1_ff <= $signed({1'b0, rot_radius}) * in_item.yaw_rate;
         job_ff <= job_in;
      end
   end
   assign out_valid = v2_ff;
   assign out_job = job_ff;
endmodule

[hw/rtl/swk_queue.sv]
// small fifo between front and back ends
`timescale 1ns / 1ps
module swk_queue import swk_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_en,
   input  job_type wr_data,
   input  logic    rd_en,
   output logic    rd_valid,
   output job_type rd_data,
   output logic [QAW:0] count
);
   job_type mem_ff [QDEPTH];
   logic [QAW-1:0] wp_ff, rp_ff;
   logic [QAW:0] cnt_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (wr_en) wp_ff <= wp_ff + 1'b1;
         if (rd_en) rp_ff <= rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (QAW+1)'(wr_en) - (QAW+1)'(rd_en);
      end
      if (wr_en) mem_ff[wp_ff] <= wr_data;
   end
   assign rd_valid = cnt_ff != '0;
   assign rd_data = mem_ff[rp_ff];
   assign count = cnt_ff;
endmodule

[hw/rtl/swk_back.sv]
// back end: four pipelined cordic vectoring units and output scaling
`timescale 1ns / 1ps
module swk_back import swk_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  job_type in_job,
   input  logic    advance,
   output logic    out_valid,
   output rsp_type out_item
);
   localparam int NS = CORDIC_STAGES + 3;
   logic [NS-1:0] v_ff;
   logic [NS-1:0] en_ff;
   cstage_type st_ff [4][CORDIC_STAGES+1];
   logic [27:0] mx_ff [4];
   logic signed [ZW-1:0] mz_ff [4];
   logic mzero_ff [4];
   logic [51:0] mag_ff [4];
   logic signed [ZW-1:0] z2_ff [4];
   logic zero2_ff [4];
   logic [17:0] spd [4];
   logic signed [15:0] ang [4];

   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else if (advance) v_ff <= {v_ff[NS-2:0], in_valid};
      if (advance) en_ff <= {en_ff[NS-2:0], in_job.enabled};
   end

   for (genvar w = 0; w < 4; w++) begin : g_wheel
      cstage_type s0;
      logic signed [23:0] wx, wy;
      assign wx = in_job.wheel[w].x;
      assign wy = in_job.wheel[w].y;
      always_comb begin
         s0.zero = (wx == '0) && (wy == '0);
         s0.z = '0;
         s0.x = XW'(wx) <<< 8;
         s0.y = XW'(wy) <<< 8;
         if (wx < 0) begin
            if (wy >= 0) begin
               s0.x = XW'(wy) <<< 8;
               s0.y = (-XW'(wx)) <<< 8;
               s0.z = HALF_PI_Q24;
            end else begin
               s0.x = (-XW'(wy)) <<< 8;
               s0.y = XW'(wx) <<< 8;
               s0.z = -HALF_PI_Q24;
            end
         end
      end
      always_ff @(posedge clock) if (advance) st_ff[w][0] <= s0;

      for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
         cstage_type a, b;
         assign a = st_ff[w][i];
         always_comb begin
            b = a;
            if (a.y >= 0) begin
               b.x = a.x + (a.y >>> i);
               b.y = a.y - (a.x >>> i);
               b.z = a.z + atan_q24(i);
            end else begin
               b.x = a.x - (a.y >>> i);
               b.y = a.y + (a.x >>> i);
               b.z = a.z - atan_q24(i);
            end
         end
         always_ff @(posedge clock) if (advance) st_ff[w][i+1] <= b;
      end

      // x never goes negative here; anything at or above 2^28 saturates the speed anyway
      always_ff @(posedge clock) begin
         if (advance) begin
            mx_ff[w] <= (|st_ff[w][CORDIC_STAGES].x[XW-1:28]) ? '1
                                                               : st_ff[w][CORDIC_STAGES].x[27:0];
            mz_ff[w] <= st_ff[w][CORDIC_STAGES].z;
            mzero_ff[w] <= st_ff[w][CORDIC_STAGES].zero;
            mag_ff[w] <= mx_ff[w] * GAIN_Q24 + 52'h8000_0000;
            z2_ff[w] <= mz_ff[w];
            zero2_ff[w] <= mzero_ff[w];
         end
      end

      logic [19:0] m;
      logic signed [ZW-1:0] zr;
      logic signed [ZW-12:0] a;
      assign m = mag_ff[w][51:32];
      assign zr = z2_ff[w] + ZW'(1024);
      assign a = zr[ZW-1:11];
      always_comb begin
         if (zero2_ff[w]) spd[w] = '0;
         else if (m > 20'd262143) spd[w] = SPEED_MAX;
         else spd[w] = m[17:0];
         if (zero2_ff[w]) ang[w] = '0;
         else if (a > 17'(ANGLE_MAX)) ang[w] = ANGLE_MAX;
         else if (a < -17'(ANGLE_MAX)) ang[w] = -ANGLE_MAX;
         else ang[w] = a[15:0];
         if (!en_ff[NS-1]) begin
            spd[w] = '0;
            ang[w] = '0;
         end
      end
   end

   assign out_valid = v_ff[NS-1];
   always_comb begin
      out_item.speed_front_left = spd[0];
      out_item.speed_front_right = spd[1];
      out_item.speed_back_left = spd[2];
      out_item.speed_back_right = spd[3];
      out_item.angle_front_left = ang[0];
      out_item.angle_front_right = ang[1];
      out_item.angle_back_left = ang[2];
      out_item.angle_back_right = ang[3];
      out_item.motors_enabled = en_ff[NS-1];
   end
endmodule

[hw/rtl/swerve_drive_wheel_kinematics_top.sv]
// path: front stages, queue, back stages (pre-rotation, CORDIC, magnitude, scaling), output register
// throughput: one item per cycle while the result side takes items
// front pipeline stalls when the queue may fill; back pipeline stalls on a full output
// reset: synchronous active high, clears valids and queue; drive_mode 0, radius 50
`timescale 1ns / 1ps
module swerve_drive_wheel_kinematics_top import swk_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data,
   input  logic    csr_valid,
   output logic    csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   // configuration registers
   logic drive_mode_ff;
   logic [11:0] rot_radius_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         drive_mode_ff <= 1'b0;
         rot_radius_ff <= 12'd50;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_DRIVE_MODE: drive_mode_ff <= csr_wdata[0];
            CSR_ROT_RADIUS: rot_radius_ff <= csr_wdata[11:0];
            default: ;
         endcase
      end
   end
   assign csr_ready = 1'b1;

   // front: free running; stalls only when queue plus front could overflow
   logic fr_adv, fr_valid, q_rd, q_valid, bk_adv, bk_valid;
   job_type fr_job, q_job;
   logic [QAW:0] q_count;
   assign fr_adv = q_count <= (QAW+1)'(QDEPTH - 3) || q_rd;
   assign req_ready = fr_adv;

   swk_front u_front (
      .clock, .reset,
      .in_valid(req_valid && req_ready), .in_item(req_data),
      .drive_mode(drive_mode_ff), .rot_radius(rot_radius_ff),
      .advance(fr_adv), .out_valid(fr_valid), .out_job(fr_job)
   );

   swk_queue u_queue (
      .clock, .reset,
      .wr_en(fr_valid && fr_adv), .wr_data(fr_job),
      .rd_en(q_rd), .rd_valid(q_valid), .rd_data(q_job), .count(q_count)
   );

   // back stalls when its final result cannot move into the output register
   logic out_v_ff;
   rsp_type out_d_ff;
   rsp_type bk_item;
   assign bk_adv = !(bk_valid && out_v_ff && !rsp_ready);
   assign q_rd = q_valid && bk_adv;

   swk_back u_back (
      .clock, .reset,
      .in_valid(q_rd), .in_job(q_job), .advance(bk_adv),
      .out_valid(bk_valid), .out_item(bk_item)
   );

   always_ff @(posedge clock) begin
      if (reset) out_v_ff <= 1'b0;
      else if (bk_adv) out_v_ff <= bk_valid || (out_v_ff && !rsp_ready);
      else if (rsp_ready) out_v_ff <= 1'b0;
      if (bk_adv && bk_valid) out_d_ff <= bk_item;
   end
   assign rsp_valid = out_v_ff;
   assign rsp_data = out_d_ff;
endmodule

[hw/rtl/swk_checker.sv]
// port-level checker bound to the swerve kinematics top
`timescale 1ns / 1ps
`include "swerve_drive_wheel_kinematics_top_macros.svh"
module swk_checker import swk_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);
   `SWK_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
   `SWK_ASSERT_IMP(a_relax_zero, clock, reset, rsp_valid && !rsp_data.motors_enabled, rsp_data.speed_front_left == '0 && rsp_data.angle_back_right == '0)
   `SWK_ASSERT_IMP(a_ang_range, clock, reset, rsp_valid, rsp_data.angle_front_left <= ANGLE_MAX && rsp_data.angle_front_left >= -ANGLE_MAX)
   `SWK_ASSERT_IMP(a_req_known, clock, reset, req_valid, !$isunknown(req_ready))
endmodule

bind swerve_drive_wheel_kinematics_top swk_checker u_swk_checker (
   .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready, .rsp_data
);
